// ----- rtl/window_sum_argmax_macros.svh -----
// Assertion macros for the window sum search block.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef WINDOW_SUM_ARGMAX_MACROS_SVH
`define WINDOW_SUM_ARGMAX_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WSA_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("window_sum_argmax: invariant violated");
`define WSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("window_sum_argmax: sequence violated");
`else
`define WSA_ASSERT_ALWAYS(label, expr)
`define WSA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/wsa_pkg.sv -----
package wsa_pkg;

   localparam int CFG_DATA_BITS   = 11;
   localparam int CFG_WINDOW_BITS = 5;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int SUM_OUT_BITS    = 24;
   localparam int COORD_OUT_BITS  = 10;
   localparam int OUT_DEPTH       = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_WINDOW_SIZE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SUM_OUT_BITS-1:0]   best_sum;
      logic [COORD_OUT_BITS-1:0] center_x;
      logic [COORD_OUT_BITS-1:0] center_y;
      logic                      found;
   } rsp_item_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

endpackage

// ----- rtl/wsa_fifo.sv -----
module wsa_fifo
   import wsa_pkg::*;
#(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   item_type              store_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff,  count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/wsa_front.sv -----
module wsa_front
   import wsa_pkg::*;
#(
   parameter type q_item_type = logic,
   parameter int  MAX_WIDTH   = 1024,
   parameter int  MAX_HEIGHT  = 1024,
   parameter int  MAX_WINDOW  = 16,
   parameter int  SAMPLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_DATA_BITS-1:0]  csr_wdata,
   input  back_status_type           back_status,
   output logic                      q_valid,
   input  logic                      q_ready,
   output q_item_type                q_item
);

   localparam int CB  = $clog2(MAX_WIDTH);
   localparam int YB  = $clog2(MAX_HEIGHT);
   localparam int LB  = $clog2(MAX_WINDOW);
   localparam int WB  = $clog2(MAX_WIDTH + 1);
   localparam int HB  = $clog2(MAX_HEIGHT + 1);
   localparam int M1  = (WB > HB) ? WB : HB;
   localparam int PB  = ((M1 > CFG_DATA_BITS) ? M1 : CFG_DATA_BITS) + 1;

   logic [CFG_DATA_BITS-1:0]   fw_ff, fh_ff;
   logic [CFG_WINDOW_BITS-1:0] ws_ff;
   logic [CB-1:0]              col_ff, col_in;
   logic [YB-1:0]              row_ff, row_in;
   logic [LB-1:0]              slot_ff, slot_in;
   logic [PB-1:0]              w_p, h_p, k_p, fw_p, fh_p, ws_p, c_p, r_p, slot_p;
   logic                       accept, last_col, last_row;

   assign csr_ready = 1'b1;
   assign req_ready = q_ready && !back_status.busy;
   assign q_valid   = req_valid && !back_status.busy;
   assign accept    = req_valid && req_ready;

   // Saturate the registers into their legal ranges.
   always_comb begin
      fw_p = PB'(fw_ff);
      fh_p = PB'(fh_ff);
      ws_p = PB'(ws_ff);
      if (fw_p == '0)                   w_p = PB'(1);
      else if (fw_p > PB'(MAX_WIDTH))   w_p = PB'(MAX_WIDTH);
      else                              w_p = fw_p;
      if (fh_p == '0)                   h_p = PB'(1);
      else if (fh_p > PB'(MAX_HEIGHT))  h_p = PB'(MAX_HEIGHT);
      else                              h_p = fh_p;
      if (ws_p == '0)                   k_p = PB'(1);
      else if (ws_p > PB'(MAX_WINDOW))  k_p = PB'(MAX_WINDOW);
      else                              k_p = ws_p;
   end

   always_comb begin
      c_p      = PB'(col_ff);
      r_p      = PB'(row_ff);
      slot_p   = PB'(slot_ff);
      last_col = (c_p + PB'(1)) >= w_p;
      last_row = (r_p + PB'(1)) >= h_p;

      q_item          = '0;
      q_item.sample   = req_sample;
      q_item.col      = col_ff;
      q_item.wr_row   = slot_ff;
      q_item.rd_row   = (slot_p >= k_p) ? LB'(slot_p - k_p)
                                        : LB'(slot_p + PB'(MAX_WINDOW) - k_p);
      q_item.hist_idx = LB'(k_p - PB'(1));
      q_item.row0     = (row_ff == '0);
      q_item.col0     = (col_ff == '0);
      q_item.sub_line = (r_p >= k_p);
      q_item.sub_col  = (c_p >= k_p);
      q_item.win      = ((r_p + PB'(1)) >= k_p) && ((c_p + PB'(1)) >= k_p);
      q_item.last     = last_col && last_row;
      q_item.cx       = CB'(c_p + PB'(1) - k_p + (k_p >> 1));
      q_item.cy       = YB'(r_p + PB'(1) - k_p + (k_p >> 1));
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + YB'(1);
               slot_in = (slot_ff == LB'(MAX_WINDOW - 1)) ? '0 : slot_ff + LB'(1);
            end
         end else begin
            col_in = col_ff + CB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= CFG_DATA_BITS'(1);
         fh_ff   <= CFG_DATA_BITS'(1);
         ws_ff   <= CFG_WINDOW_BITS'(1);
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  fw_ff <= csr_wdata;
               CSR_FRAME_HEIGHT: fh_ff <= csr_wdata;
               CSR_WINDOW_SIZE:  ws_ff <= csr_wdata[CFG_WINDOW_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- rtl/wsa_back.sv -----
module wsa_back
   import wsa_pkg::*;
#(
   parameter type q_item_type = logic,
   parameter int  MAX_WIDTH   = 1024,
   parameter int  MAX_HEIGHT  = 1024,
   parameter int  MAX_WINDOW  = 16,
   parameter int  SAMPLE_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   output logic            q_ready,
   input  q_item_type      q_item,
   output logic            res_valid,
   output rsp_item_type    res_item,
   input  logic            rsp_taken,
   output back_status_type back_status
);

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int YB = $clog2(MAX_HEIGHT);
   localparam int CS = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int RS = SAMPLE_BITS + 2 * $clog2(MAX_WINDOW);
   localparam int NB = $clog2(OUT_DEPTH + 1);

   logic [CS-1:0]          colmem   [MAX_WIDTH];
   logic [SAMPLE_BITS-1:0] linemem  [MAX_WINDOW][MAX_WIDTH];
   logic [CS-1:0]          hist_ff  [MAX_WINDOW];

   logic                   clear_ff;
   logic [CB-1:0]          clr_ff;
   logic [NB-1:0]          out_cnt_ff, out_cnt_in;
   logic                   pop;

   logic                   s1_v_ff, s2_v_ff, s3_v_ff;
   q_item_type             s1_item_ff, s2_item_ff, s3_item_ff;
   logic [CS-1:0]          colrd_ff;
   logic [SAMPLE_BITS-1:0] linerd_ff;
   logic                   fwd_v_ff;
   logic [CB-1:0]          fwd_c_ff;
   logic [CS-1:0]          fwd_data_ff;
   logic [CS-1:0]          col_base, colsum, s2_colsum_ff;
   logic [RS-1:0]          rws_ff, rws_in, s3_rws_ff;

   logic [RS-1:0]          best_ff, best_in;
   logic [CB-1:0]          bx_ff, bx_in;
   logic [YB-1:0]          by_ff, by_in;
   logic                   any_ff, any_in;

   assign back_status.busy = clear_ff;

   // Results are reserved when the last sample of a frame leaves the queue,
   // so the result queue can never overflow.
   assign q_ready = !clear_ff && (!q_item.last || (out_cnt_ff < NB'(OUT_DEPTH)));
   assign pop     = q_valid && q_ready;

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if ((pop && q_item.last) && !rsp_taken) out_cnt_in = out_cnt_ff + NB'(1);
      else if (!(pop && q_item.last) && rsp_taken) out_cnt_in = out_cnt_ff - NB'(1);
   end

   // Column sum memory: cleared once after reset, then read at pop time and
   // written back in the cycle after.
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         colmem[clr_ff] <= '0;
      end else if (s1_v_ff) begin
         colmem[s1_item_ff.col] <= colsum;
      end
      if (pop) begin
         colrd_ff <= colmem[q_item.col];
      end
   end

   // Line store: the read sees the old entry even when it shares the slot.
   always_ff @(posedge clock) begin
      if (pop) begin
         linerd_ff <= linemem[q_item.rd_row][q_item.col];
         linemem[q_item.wr_row][q_item.col] <= q_item.sample;
      end
   end

   always_comb begin
      col_base = (fwd_v_ff && (fwd_c_ff == s1_item_ff.col)) ? fwd_data_ff : colrd_ff;
      colsum   = (s1_item_ff.row0 ? '0 : col_base) + CS'(s1_item_ff.sample)
               - (s1_item_ff.sub_line ? CS'(linerd_ff) : '0);
   end

   always_comb begin
      if (s2_item_ff.col0) begin
         rws_in = RS'(s2_colsum_ff);
      end else begin
         rws_in = rws_ff + RS'(s2_colsum_ff)
                - (s2_item_ff.sub_col ? RS'(hist_ff[s2_item_ff.hist_idx]) : '0);
      end
   end

   always_comb begin
      best_in = best_ff;
      bx_in   = bx_ff;
      by_in   = by_ff;
      any_in  = any_ff;
      if (s3_item_ff.win) begin
         any_in = 1'b1;
         if (s3_rws_ff >= best_ff) begin
            best_in = s3_rws_ff;
            bx_in   = s3_item_ff.cx;
            by_in   = s3_item_ff.cy;
         end
      end
      res_valid         = s3_v_ff && s3_item_ff.last;
      res_item.best_sum = SUM_OUT_BITS'(best_in);
      res_item.center_x = COORD_OUT_BITS'(bx_in);
      res_item.center_y = COORD_OUT_BITS'(by_in);
      res_item.found    = any_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_ff     <= '0;
         out_cnt_ff <= '0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         fwd_v_ff   <= 1'b0;
         rws_ff     <= '0;
         best_ff    <= '0;
         bx_ff      <= '0;
         by_ff      <= '0;
         any_ff     <= 1'b0;
      end else begin
         if (clear_ff) begin
            clr_ff <= clr_ff + CB'(1);
            if (clr_ff == CB'(MAX_WIDTH - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         out_cnt_ff <= out_cnt_in;
         s1_v_ff    <= pop;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         fwd_v_ff   <= s1_v_ff;
         if (s2_v_ff) begin
            rws_ff <= rws_in;
         end
         if (s3_v_ff) begin
            if (s3_item_ff.last) begin
               best_ff <= '0;
               bx_ff   <= '0;
               by_ff   <= '0;
               any_ff  <= 1'b0;
            end else begin
               best_ff <= best_in;
               bx_ff   <= bx_in;
               by_ff   <= by_in;
               any_ff  <= any_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff   <= q_item;
      s2_item_ff   <= s1_item_ff;
      s3_item_ff   <= s2_item_ff;
      s2_colsum_ff <= colsum;
      s3_rws_ff    <= rws_in;
      fwd_c_ff     <= s1_item_ff.col;
      fwd_data_ff  <= colsum;
      if (s2_v_ff) begin
         hist_ff[0] <= s2_colsum_ff;
         for (int i = 1; i < MAX_WINDOW; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

endmodule

// ----- rtl/window_sum_argmax.sv -----
// Box-sum maximum search. The block takes one sample per item in raster
// order, sums every square window of side window_size that lies fully inside
// a frame_width by frame_height frame, and after the last sample of the frame
// returns one item with the largest sum, the window centre (top-left corner
// plus window_size/2) and a found flag; on equal sums the later window wins,
// and a window larger than the frame returns found = 0 with zero fields.
// After reset the block clears its column sum memory and holds req_ready
// low; configuration writes are taken meanwhile. Afterwards it accepts one
// sample per cycle unless the back holds the last sample of a frame while
// all result places are reserved; the result is registered through the
// internal queue and the back stages. Up to eight results can wait for the
// consumer before the back stops taking the last sample of a frame.
// Registers should be written between frames, when no sample is in flight.
`include "window_sum_argmax_macros.svh"

module window_sum_argmax
   import wsa_pkg::*;
#(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 1024,
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SUM_OUT_BITS-1:0]   rsp_best_sum,
   output logic [COORD_OUT_BITS-1:0] rsp_center_x,
   output logic [COORD_OUT_BITS-1:0] rsp_center_y,
   output logic                      rsp_found,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_DATA_BITS-1:0]  csr_wdata
);

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int YB = $clog2(MAX_HEIGHT);
   localparam int LB = $clog2(MAX_WINDOW);

   // One classified sample as it travels from the front to the back.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [CB-1:0]          col;
      logic [LB-1:0]          wr_row;
      logic [LB-1:0]          rd_row;
      logic [LB-1:0]          hist_idx;
      logic                   row0;
      logic                   sub_line;
      logic                   col0;
      logic                   sub_col;
      logic                   win;
      logic                   last;
      logic [CB-1:0]          cx;
      logic [YB-1:0]          cy;
   } q_item_type;

   back_status_type back_status;
   logic            fq_valid, fq_ready;
   q_item_type      fq_item;
   logic            bq_valid, bq_ready;
   q_item_type      bq_item;
   logic            res_push_valid, res_push_ready;
   rsp_item_type    res_push_item, rsp_item;
   logic            rsp_taken;

   assign rsp_taken    = rsp_valid && rsp_ready;
   assign rsp_best_sum = rsp_item.best_sum;
   assign rsp_center_x = rsp_item.center_x;
   assign rsp_center_y = rsp_item.center_y;
   assign rsp_found    = rsp_item.found;

   // The front tracks the raster position and tags each sample.
   wsa_front #(
      .q_item_type (q_item_type),
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .back_status (back_status),
      .q_valid     (fq_valid),
      .q_ready     (fq_ready),
      .q_item      (fq_item)
   );

   // Short queue so the front keeps taking samples while the back waits
   // for room in the result queue.
   wsa_fifo #(
      .item_type (q_item_type),
      .DEPTH     (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (bq_valid),
      .pop_ready  (bq_ready),
      .pop_item   (bq_item)
   );

   // The back updates column and row sums and the best-window tracker.
   wsa_back #(
      .q_item_type (q_item_type),
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (bq_valid),
      .q_ready     (bq_ready),
      .q_item      (bq_item),
      .res_valid   (res_push_valid),
      .res_item    (res_push_item),
      .rsp_taken   (rsp_taken),
      .back_status (back_status)
   );

   // Result queue; the back reserves a place before a result is started.
   wsa_fifo #(
      .item_type (rsp_item_type),
      .DEPTH     (OUT_DEPTH)
   ) u_results (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_push_valid),
      .push_ready (res_push_ready),
      .push_item  (res_push_item),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_item   (rsp_item)
   );

   // The clearing pass runs once after reset and never comes back.
   `WSA_ASSERT_NEXT(a_clear_once, !back_status.busy, !back_status.busy)
   // No sample is taken while the column sums are being cleared.
   `WSA_ASSERT_ALWAYS(a_no_accept_in_clear, !(back_status.busy && req_ready))
   // The reservation scheme must leave room for every finished result.
   `WSA_ASSERT_ALWAYS(a_result_room, !(res_push_valid && !res_push_ready))

endmodule

// ----- tb/window_sum_argmax_checker.sv -----
module window_sum_argmax_checker
   import wsa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [15:0]               req_sample,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [SUM_OUT_BITS-1:0]   rsp_best_sum,
   input  logic [COORD_OUT_BITS-1:0] rsp_center_x,
   input  logic [COORD_OUT_BITS-1:0] rsp_center_y,
   input  logic                      rsp_found,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        rsp_count
);

   logic [CFG_DATA_BITS-1:0] width_reg, height_reg;
   logic [4:0]               window_reg;

   // Last sixteen rows of samples and the per-column vertical sums.
   logic [15:0]     row_history [16][1024];
   longint unsigned column_acc [1024];
   longint unsigned run_sum, peak_sum;
   int unsigned     peak_x, peak_y, col_pos, row_pos;
   bit              window_seen;
   rsp_item_type    best_window_q [$];

   function automatic int unsigned saturate(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic restart_frame();
      run_sum = 0;
      peak_sum = 0;
      peak_x = 0;
      peak_y = 0;
      window_seen = 0;
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic absorb_sample(input logic [15:0] s);
      int unsigned w, h, k, c, r;
      longint unsigned colsum;
      rsp_item_type res;
      w = saturate(width_reg, 1024);
      h = saturate(height_reg, 1024);
      k = saturate(window_reg, 16);
      c = col_pos;
      r = row_pos;
      if (r == 0) begin
         colsum = s;
      end else begin
         colsum = column_acc[c] + s;
         if (r >= k) colsum -= row_history[(r - k) % 16][c];
      end
      row_history[r % 16][c] = s;
      column_acc[c] = colsum;
      if (c == 0) begin
         run_sum = colsum;
      end else begin
         run_sum += colsum;
         if (c >= k) run_sum -= column_acc[c - k];
      end
      // Equal sums move the best window forward, so the later window wins.
      if (r + 1 >= k && c + 1 >= k) begin
         if (run_sum >= peak_sum) begin
            peak_sum = run_sum;
            peak_x = c + 1 - k + k / 2;
            peak_y = r + 1 - k + k / 2;
         end
         window_seen = 1;
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         if (r + 1 >= h) begin
            res = '0;
            if (window_seen) begin
               res.best_sum = peak_sum[SUM_OUT_BITS-1:0];
               res.center_x = peak_x[COORD_OUT_BITS-1:0];
               res.center_y = peak_y[COORD_OUT_BITS-1:0];
               res.found    = 1'b1;
            end
            best_window_q.push_back(res);
            restart_frame();
         end else begin
            row_pos = r + 1;
         end
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type exp_item;
      if (reset) begin
         width_reg  <= 1;
         height_reg <= 1;
         window_reg <= 1;
         for (int i = 0; i < 1024; i++) column_acc[i] = 0;
         best_window_q.delete();
         restart_frame();
         fail_count <= 0;
         rsp_count  <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_reg  <= csr_wdata;
               CSR_FRAME_HEIGHT: height_reg <= csr_wdata;
               CSR_WINDOW_SIZE:  window_reg <= csr_wdata[4:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) absorb_sample(req_sample);
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (best_window_q.size() == 0) begin
               $display("%0t: unexpected result sum=%0d x=%0d y=%0d found=%0d", $time,
                        rsp_best_sum, rsp_center_x, rsp_center_y, rsp_found);
               fail_count <= fail_count + 1;
            end else begin
               exp_item = best_window_q.pop_front();
               if (exp_item.best_sum !== rsp_best_sum || exp_item.center_x !== rsp_center_x ||
                   exp_item.center_y !== rsp_center_y || exp_item.found !== rsp_found) begin
                  $display("%0t: mismatch expected sum=%0d x=%0d y=%0d found=%0d", $time,
                           exp_item.best_sum, exp_item.center_x, exp_item.center_y,
                           exp_item.found);
                  $display("%0t:          actual   sum=%0d x=%0d y=%0d found=%0d", $time,
                           rsp_best_sum, rsp_center_x, rsp_center_y, rsp_found);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/tb_window_sum_argmax.sv -----
module tb_window_sum_argmax;
   import wsa_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [15:0]               req_sample;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [SUM_OUT_BITS-1:0]   rsp_best_sum;
   logic [COORD_OUT_BITS-1:0] rsp_center_x;
   logic [COORD_OUT_BITS-1:0] rsp_center_y;
   logic                      rsp_found;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_DATA_BITS-1:0]  csr_wdata;

   int fail_count;
   int rsp_count;

   // Frames whose last sample has been accepted; each one owes exactly one result.
   int frames_sent = 0;
   int random_items = 0;
   // The final stretch of the run has no idling on either side.
   bit calm = 0;
   // Requests one long hold-off on the result side.
   bit squeeze = 0;
   bit squeezed = 0;
   int cycle_count = 0;

   window_sum_argmax dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_sample,
      .rsp_valid, .rsp_ready, .rsp_best_sum, .rsp_center_x, .rsp_center_y, .rsp_found,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   window_sum_argmax_checker checker_i (
      .clock, .reset,
      .req_valid, .req_ready, .req_sample,
      .rsp_valid, .rsp_ready, .rsp_best_sum, .rsp_center_x, .rsp_center_y, .rsp_found,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .fail_count, .rsp_count
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // The run is bounded by a cycle counter; reaching the limit is a failure.
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("tb_window_sum_argmax failed");
            $finish;
         end
      end
   end

   // Result side. It stalls in short random bursts, and once it holds off for a
   // long stretch so the block's result buffer fills and it stops taking samples.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !squeezed) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            squeezed = 1;
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Registers are only touched once every owed result has come back, plus a short
   // wait so the block's output pipeline drains.
   task automatic configure(input logic [10:0] fw, input logic [10:0] fh,
                            input logic [10:0] wk);
      while (rsp_count != frames_sent) @(posedge clock);
      repeat (6) @(posedge clock);
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= (i == 0) ? fw : (i == 1) ? fh : wk;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Offers one sample and waits for it to be taken. Valid stays high across
   // back-to-back items and only drops for an idle burst.
   task automatic offer_sample(input logic [15:0] s);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [15:0] pick_sample(input int flavor);
      if (flavor == 1) begin
         case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
         endcase
      end
      if (flavor == 2) return 16'h0007;
      return 16'($urandom);
   endfunction

   // One whole frame under the registers given, saturation included.
   task automatic send_frame(input logic [10:0] fw, input logic [10:0] fh,
                             input logic [10:0] wk, input int flavor);
      int unsigned w, h;
      configure(fw, fh, wk);
      w = (fw == 0) ? 1 : (fw > 1024) ? 1024 : fw;
      h = (fh == 0) ? 1 : (fh > 1024) ? 1024 : fh;
      for (int n = 0; n < w * h; n++) offer_sample(pick_sample(flavor));
      req_valid <= 1'b0;
      frames_sent++;
   endtask

   initial begin
      int unsigned fw, fh, wk, pick;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_sample <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_FRAME_WIDTH;
      csr_wdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed frames: a single full-scale sample, a window that does not fit
      // the frame, and a frame of equal samples where the last window must win.
      configure(11'd1, 11'd1, 11'd1);
      offer_sample(16'hFFFF);
      req_valid <= 1'b0;
      frames_sent++;
      send_frame(11'd2, 11'd2, 11'd3, 0);
      send_frame(11'd3, 11'd3, 11'd2, 2);

      // Many one-sample frames while the result side holds off for a long time.
      configure(11'd1, 11'd1, 11'd1);
      squeeze = 1;
      for (int n = 0; n < 40; n++) begin
         offer_sample(pick_sample(0));
         frames_sent++;
      end
      req_valid <= 1'b0;
      random_items += 40;

      // Register extremes: a zero height with a saturated window that cannot fit, a full-size
      // window that exactly fills its frame, and a zero width with a zero window.
      send_frame(11'd5, 11'd0, 11'd31, 1);
      send_frame(11'd16, 11'd16, 11'd31, 1);
      send_frame(11'd0, 11'd5, 11'd0, 1);
      random_items += 5 + 256 + 5;

      while (random_items < 1040) begin
         if (random_items > 890) calm = 1;
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            fw = $urandom_range(1, 14);
            fh = $urandom_range(1, 14);
            wk = $urandom_range(1, 8);
         end else begin
            fw = $urandom_range(1, 20);
            fh = $urandom_range(1, 20);
            wk = $urandom_range(9, 16);
         end
         send_frame(fw[10:0], fh[10:0], wk[10:0], $urandom_range(0, 1));
         random_items += fw * fh;
      end

      while (rsp_count != frames_sent) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_window_sum_argmax passed");
      end else begin
         $display("tb_window_sum_argmax failed");
      end
      $finish;
   end

endmodule

// ----- window_sum_argmax.f -----
+incdir+rtl
rtl/wsa_pkg.sv
rtl/wsa_fifo.sv
rtl/wsa_front.sv
rtl/wsa_back.sv
rtl/window_sum_argmax.sv
tb/window_sum_argmax_checker.sv
tb/tb_window_sum_argmax.sv
